// ----- rtl/avi_ts_pkg.sv -----
`timescale 1ns / 1ps

package avi_ts_pkg;

   // Item kinds on the request channel.
   localparam logic REQ_DEFINE = 1'b0;
   localparam logic REQ_ENTRY  = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_OFFSET_BASE = 1'b0;
   localparam logic CSR_FILE_LENGTH = 1'b1;

   // Entry format constants.
   localparam int          KEYFRAME_BIT = 4;
   localparam logic [7:0]  ASCII_ZERO   = 8'h30;
   localparam logic [7:0]  ASCII_NINE   = 8'h39;
   localparam logic [40:0] HEADER_BYTES = 41'd8;

   // Bits handled by the serial divider and multiplier, one per cycle.
   localparam int DIGITS = 32;
   localparam int CNT_W  = $clog2(DIGITS);

   typedef struct packed {
      logic        req_type;
      logic [1:0]  track_slot;
      logic [6:0]  stream_number;
      logic [31:0] time_scale;
      logic [31:0] stream_start;
      logic [31:0] unit_size;
      logic        is_audio;
      logic [31:0] chunk_tag;
      logic [31:0] entry_flags;
      logic [31:0] rel_offset;
      logic [31:0] byte_size;
   } req_item_type;

   typedef struct packed {
      logic               sample_valid;
      logic               bounds_error;
      logic [1:0]         sample_track;
      logic [39:0]        data_offset;
      logic [31:0]        payload_bytes;
      logic signed [63:0] timestamp;
      logic [31:0]        duration;
      logic               sync;
      logic [31:0]        sample_number;
   } rsp_item_type;

   // Status of the serial divide and scale unit.
   typedef struct packed {
      logic done;
      logic q_nonzero;
      logic overflow;
   } div_status_type;

endpackage

// ----- rtl/avi_ts_serial_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first. Each quotient bit
// is folded into a running product scale * quotient (Horner form), with a
// sticky flag once the product leaves 32 bits.
module avi_ts_serial_div
   import avi_ts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  logic [31:0]    dividend,
   input  logic [31:0]    divisor,
   input  logic [31:0]    scale,
   output div_status_type status,
   output logic [31:0]    product
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [31:0]      dividend_ff;
   logic [31:0]      divisor_ff;
   logic [31:0]      scale_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      prod_ff;
   logic             ovf_ff;
   logic             qnz_ff;

   logic [32:0] trial;
   logic        ge;
   logic [32:0] diff;
   logic [33:0] sum;

   always_comb begin
      trial = {rem_ff, dividend_ff[31]};
      ge    = trial >= {1'b0, divisor_ff};
      diff  = trial - {1'b0, divisor_ff};
      sum   = {1'b0, prod_ff, 1'b0} + {2'b00, (ge ? scale_ff : 32'd0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff     <= 1'b1;
            cnt_ff      <= '0;
            dividend_ff <= dividend;
            divisor_ff  <= divisor;
            scale_ff    <= scale;
            rem_ff      <= '0;
            prod_ff     <= '0;
            ovf_ff      <= 1'b0;
            qnz_ff      <= 1'b0;
         end else if (busy_ff) begin
            dividend_ff <= {dividend_ff[30:0], 1'b0};
            rem_ff      <= ge ? diff[31:0] : trial[31:0];
            prod_ff     <= sum[31:0];
            ovf_ff      <= ovf_ff | (sum[33:32] != 2'b00);
            qnz_ff      <= qnz_ff | ge;
            cnt_ff      <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIGITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.done      = done_ff;
   assign status.q_nonzero = qnz_ff;
   assign status.overflow  = ovf_ff;
   assign product          = prod_ff;

endmodule

// ----- rtl/avi_ts_serial_mul.sv -----
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle, MSB first.
module avi_ts_serial_mul
   import avi_ts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] mplier,
   input  logic [31:0] mcand,
   output logic        done,
   output logic [63:0] product
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [31:0]      mplier_ff;
   logic [31:0]      mcand_ff;
   logic [63:0]      acc_ff;

   logic [63:0] acc_in;

   assign acc_in = {acc_ff[62:0], 1'b0} + {32'd0, (mplier_ff[31] ? mcand_ff : 32'd0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= '0;
            mplier_ff <= mplier;
            mcand_ff  <= mcand;
            acc_ff    <= '0;
         end else if (busy_ff) begin
            mplier_ff <= {mplier_ff[30:0], 1'b0};
            acc_ff    <= acc_in;
            cnt_ff    <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIGITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- rtl/avi_index_entry_timestamper.sv -----
// A definition goes from IDLE straight to DONE; a skipped or rejected entry passes
// through CHECK to DONE; a sample entry passes CHECK, RUN and FINISH. DONE loads the
// output register once it is free. The block takes one item at a time; RUN lasts as long
// as the 32-step serial divider (byte size by unit size) that runs beside the multiplier.
// Reset (synchronous, active high) clears the defined flags of all track slots, the
// sample counter, the sticky bounds error, both configuration registers and output valid.
`timescale 1ns / 1ps

module avi_index_entry_timestamper
   import avi_ts_pkg::*;
#(
   parameter int MAX_TRACKS = 4
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   // Result channel.
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [39:0]  csr_data
);

   localparam int SLOT_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

   // The controller walks one item at a time through these steps. A definition
   // goes straight to DONE; an entry is checked, then the serial units run unless it is skipped or out of bounds.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_FINISH,
      ST_DONE
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [32:0] offset_base_ff;
   logic [39:0] file_length_ff;

   // Track slot table. Only the defined flags need a reset: every other field
   // is written by the definition that sets the flag.
   logic [MAX_TRACKS-1:0] slot_defined_ff;
   logic [6:0]            slot_stream_ff  [MAX_TRACKS];
   logic [31:0]           slot_scale_ff   [MAX_TRACKS];
   logic [31:0]           slot_start_ff   [MAX_TRACKS];
   logic [31:0]           slot_unit_ff    [MAX_TRACKS];
   logic                  slot_audio_ff   [MAX_TRACKS];
   logic [63:0]           running_time_ff [MAX_TRACKS];

   logic [31:0] samples_ff;
   logic        error_ff;

   // The entry being worked on.
   logic              hit_ff;
   logic [SLOT_W-1:0] found_ff;
   logic [31:0]       flags_ff;
   logic [31:0]       rel_ff;
   logic [31:0]       bytes_ff;
   logic [31:0]       scale_ff;
   logic              unit_zero_ff;
   logic              audio_ff;
   logic [63:0]       run_ff;
   logic [39:0]       offset_ff;
   logic [31:0]       dur_ff;
   logic [63:0]       ts_ff;

   // Pending result and the output register that parts it from the consumer.
   rsp_item_type res_ff;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;

   // Every item starts from an empty result that carries the latched error.
   rsp_item_type res_start;

   always_comb begin
      res_start              = '0;
      res_start.bounds_error = error_ff;
   end

   // Tag decode: the first two tag characters must be ASCII digits and give
   // the stream number as tens and units.
   logic [7:0]        tag_a;
   logic [7:0]        tag_b;
   logic              tag_ok;
   logic [6:0]        tag_stream;
   logic              match_hit;
   logic [SLOT_W-1:0] match_idx;

   always_comb begin
      tag_a      = req_data.chunk_tag[7:0] - ASCII_ZERO;
      tag_b      = req_data.chunk_tag[15:8] - ASCII_ZERO;
      tag_ok     = (req_data.chunk_tag[7:0] inside {[ASCII_ZERO:ASCII_NINE]}) &&
                   (req_data.chunk_tag[15:8] inside {[ASCII_ZERO:ASCII_NINE]});
      tag_stream = {tag_a[3:0], 3'b000} + {2'b00, tag_a[3:0], 1'b0} + {3'b000, tag_b[3:0]};
      // Scanning from the top down lets the lowest matching slot win when two
      // slots carry the same stream number.
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
         if (tag_ok && slot_defined_ff[i] && (slot_stream_ff[i] == tag_stream)) begin
            match_hit = 1'b1;
            match_idx = SLOT_W'(i);
         end
      end
   end

   // A definition for a slot that this instance does not have is dropped.
   logic              def_slot_ok;
   logic [SLOT_W-1:0] def_idx;

   assign def_slot_ok = 32'(req_data.track_slot) < MAX_TRACKS;
   assign def_idx     = SLOT_W'(req_data.track_slot);

   // Bounds check: the payload must end at or before the file length. The sum
   // is carried at 41 bits so a wrap can never hide an overrun.
   logic [40:0] hdr_end;
   logic [40:0] payload_end;
   logic        out_of_bounds;
   logic        skip_entry;
   logic        serial_go;

   always_comb begin
      hdr_end       = {8'd0, offset_base_ff} + {9'd0, rel_ff} + HEADER_BYTES;
      payload_end   = hdr_end + {9'd0, bytes_ff};
      out_of_bounds = payload_end > {1'b0, file_length_ff};
      skip_entry    = error_ff || !hit_ff || (bytes_ff == 32'd0);
      serial_go     = (state_ff == ST_CHECK) && !skip_entry && !out_of_bounds;
   end

   // Serial units: the divider also forms scale * (bytes / unit) as the
   // quotient bits appear, while the multiplier forms start * scale.
   div_status_type div_stat;
   logic [31:0]    div_product;
   logic           mul_done;
   logic [63:0]    mul_product;

   avi_ts_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (serial_go),
      .dividend (bytes_ff),
      .divisor  (slot_unit_ff[found_ff]),
      .scale    (slot_scale_ff[found_ff]),
      .status   (div_stat),
      .product  (div_product)
   );

   avi_ts_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (serial_go),
      .mplier  (slot_start_ff[found_ff]),
      .mcand   (slot_scale_ff[found_ff]),
      .done    (mul_done),
      .product (mul_product)
   );

   // Duration: the track scale when the unit size is zero or the entry holds
   // less than one unit, saturated when the product leaves 32 bits.
   logic [31:0] dur_calc;

   always_comb begin
      if (unit_zero_ff || !div_stat.q_nonzero) begin
         dur_calc = scale_ff;
      end else if (div_stat.overflow) begin
         dur_calc = '1;
      end else begin
         dur_calc = div_product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         offset_base_ff  <= '0;
         file_length_ff  <= '0;
         slot_defined_ff <= '0;
         samples_ff      <= '0;
         error_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
         if (csr_valid) begin
            case (csr_index)
               CSR_OFFSET_BASE: offset_base_ff <= csr_data[32:0];
               CSR_FILE_LENGTH: file_length_ff <= csr_data;
               default: ;
            endcase
         end

         // In DONE the output register is reloaded below, so only drop valid here
         // when no new item is handed over.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  res_ff <= res_start;
                  if (req_data.req_type == REQ_DEFINE) begin
                     if (def_slot_ok) begin
                        slot_stream_ff[def_idx]  <= req_data.stream_number;
                        slot_scale_ff[def_idx]   <= req_data.time_scale;
                        slot_start_ff[def_idx]   <= req_data.stream_start;
                        slot_unit_ff[def_idx]    <= req_data.unit_size;
                        slot_audio_ff[def_idx]   <= req_data.is_audio;
                        slot_defined_ff[def_idx] <= req_data.time_scale != 32'd0;
                        running_time_ff[def_idx] <= '0;
                     end
                     state_ff <= ST_DONE;
                  end else begin
                     hit_ff   <= match_hit;
                     found_ff <= match_idx;
                     flags_ff <= req_data.entry_flags;
                     rel_ff   <= req_data.rel_offset;
                     bytes_ff <= req_data.byte_size;
                     state_ff <= ST_CHECK;
                  end
               end
            end

            ST_CHECK: begin
               if (skip_entry) begin
                  state_ff <= ST_DONE;
               end else if (out_of_bounds) begin
                  // The error sticks until reset and blocks all later entries.
                  error_ff            <= 1'b1;
                  res_ff.bounds_error <= 1'b1;
                  state_ff            <= ST_DONE;
               end else begin
                  scale_ff     <= slot_scale_ff[found_ff];
                  unit_zero_ff <= slot_unit_ff[found_ff] == 32'd0;
                  audio_ff     <= slot_audio_ff[found_ff];
                  run_ff       <= running_time_ff[found_ff];
                  offset_ff    <= hdr_end[39:0];
                  state_ff     <= ST_RUN;
               end
            end

            ST_RUN: begin
               if (div_stat.done) begin
                  dur_ff   <= dur_calc;
                  ts_ff    <= run_ff + mul_product;
                  state_ff <= ST_FINISH;
               end
            end

            ST_FINISH: begin
               running_time_ff[found_ff] <= run_ff + {32'd0, dur_ff};
               samples_ff                <= samples_ff + 32'd1;
               res_ff.sample_valid       <= 1'b1;
               res_ff.bounds_error       <= 1'b0;
               res_ff.sample_track       <= 2'(found_ff);
               res_ff.data_offset        <= offset_ff;
               res_ff.payload_bytes      <= bytes_ff;
               res_ff.timestamp          <= ts_ff;
               res_ff.duration           <= dur_ff;
               res_ff.sync               <= audio_ff | flags_ff[KEYFRAME_BIT];
               res_ff.sample_number      <= samples_ff;
               state_ff                  <= ST_DONE;
            end

            ST_DONE: begin
               // Hand the result over once the output register is free.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Nothing is taken on an edge that the synchronous reset claims.
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = !reset;

   // The two serial units start together and run the same number of steps.
   a_units_in_step: assert property (@(posedge clock) disable iff (reset)
      div_stat.done == mul_done)
      else $error("divider and multiplier finished on different cycles");

   // Once latched, the bounds error holds until reset.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("bounds error cleared without reset");

   // A delivered sample never carries the error flag.
   a_sample_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.sample_valid |-> !rsp_ff.bounds_error)
      else $error("sample item reported with bounds error");

   // The sample counter moves only when a sample is committed.
   a_counter_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_FINISH |=> samples_ff == $past(samples_ff))
      else $error("sample counter changed outside commit");

   // The serial units finish only while the controller waits for them.
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_RUN)
      else $error("serial unit finished outside the run step");

endmodule
